### hdl/fr_pkg.sv
// shared types and codes for the fraction reducer
package fr_pkg;

  localparam int FORM_BITS = 2;

  typedef logic [FORM_BITS-1:0] form_t;

  localparam form_t FORM_ZERO     = 2'd0;
  localparam form_t FORM_ONE      = 2'd1;
  localparam form_t FORM_WHOLE    = 2'd2;
  localparam form_t FORM_FRACTION = 2'd3;

  typedef logic [1:0] div_sel_t;

  localparam div_sel_t DIV_MOD = 2'd0;
  localparam div_sel_t DIV_NUM = 2'd1;
  localparam div_sel_t DIV_DEN = 2'd2;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     step;
    logic     store_num;
    logic     store_den;
    logic     emit;
  } fr_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic g_gt1;
    logic div_done;
  } fr_status_t;

endpackage

### hdl/fr_div.sv
// restoring divider, one quotient bit per cycle
module fr_div #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         done
);

  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_LOAD = CW'(W);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          running;
  logic [W:0]    trial;
  logic          neg;

  assign trial = {rem, quo[W-1]} - {1'b0, dsr};
  assign neg   = trial[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= !start && running && (cnt == CNT_ONE);
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_LOAD;
      end else if (running) begin
        cnt <= cnt - CNT_ONE;
        if (cnt == CNT_ONE) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (running) begin
      rem <= neg ? {rem[W-2:0], quo[W-1]} : trial[W-1:0];
      quo <= {quo[W-2:0], ~neg};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### hdl/fr_datapath.sv
// gcd and reduction datapath
module fr_datapath #(
  parameter int W = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  fr_pkg::fr_cmd_t   cmd,
  output fr_pkg::fr_status_t status,
  input  logic [W-1:0]      numerator,
  input  logic [W-1:0]      denominator,
  output logic [W-1:0]      reduced_numerator,
  output logic [W-1:0]      reduced_denominator,
  output fr_pkg::form_t     form,
  output logic              done
);
  import fr_pkg::*;

  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [W-1:0] rn;
  logic [W-1:0] rd;
  logic [W-1:0] div_dividend;
  logic [W-1:0] div_divisor;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic         div_done;
  form_t        form_next;

  always_comb begin
    case (cmd.div_sel)
      DIV_MOD: begin
        div_dividend = b;
        div_divisor  = a;
      end
      DIV_NUM: begin
        div_dividend = rn;
        div_divisor  = b;
      end
      DIV_DEN: begin
        div_dividend = rd;
        div_divisor  = b;
      end
      default: begin
        div_dividend = b;
        div_divisor  = a;
      end
    endcase
  end

  fr_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .remainder(div_rem),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a  <= numerator;
      b  <= denominator;
      rn <= numerator;
      rd <= denominator;
    end else begin
      if (cmd.step) begin
        b <= a;
        a <= div_rem;
      end
      if (cmd.store_num) rn <= div_quo;
      if (cmd.store_den) rd <= div_quo;
    end
  end

  always_comb begin
    if (rn == '0) form_next = FORM_ZERO;
    else if (rn == rd) form_next = FORM_ONE;
    else if (rd == W'(1)) form_next = FORM_WHOLE;
    else form_next = FORM_FRACTION;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      reduced_numerator   <= rn;
      reduced_denominator <= rd;
      form                <= form_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.emit;
  end

  assign status.a_zero   = (a == '0);
  assign status.g_gt1    = |b[W-1:1];
  assign status.div_done = div_done;

endmodule

### hdl/fr_ctrl.sv
// sequencing state machine for the fraction reducer
module fr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fr_pkg::fr_status_t status,
  output fr_pkg::fr_cmd_t    cmd
);
  import fr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_DIVN   = 3'd3;
  localparam logic [2:0] S_WAITN  = 3'd4;
  localparam logic [2:0] S_DIVD   = 3'd5;
  localparam logic [2:0] S_WAITD  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.div_sel   = DIV_MOD;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.a_zero) begin
          cmd.div_start = 1'b1;
          state_next    = S_MOD;
        end else if (status.g_gt1) begin
          state_next = S_DIVN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MOD: begin
        if (status.div_done) begin
          cmd.step   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_DIVN: begin
        cmd.div_sel   = DIV_NUM;
        cmd.div_start = 1'b1;
        state_next    = S_WAITN;
      end
      S_WAITN: begin
        if (status.div_done) begin
          cmd.store_num = 1'b1;
          state_next    = S_DIVD;
        end
      end
      S_DIVD: begin
        cmd.div_sel   = DIV_DEN;
        cmd.div_start = 1'b1;
        state_next    = S_WAITD;
      end
      S_WAITD: begin
        if (status.div_done) begin
          cmd.store_den = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### hdl/fraction_reducer.sv
// top level of the fraction reducer
// Reduces numerator/denominator to lowest terms with Euclid's gcd and returns
// the reduced pair with a form code (zero, one, whole, fraction). A word is
// taken when start is high and busy is low; the result is shown for exactly
// one cycle with done high and cannot be held off, so the receiver must take
// it then. One word at a time: every remainder step of the gcd and each of the
// two final divisions runs on a single shared restoring divider at one bit per
// cycle; the gcd takes at most about 1.44 * VALUE_BITS Euclid steps, and when
// the gcd is not above one the two divisions are skipped.
module fraction_reducer #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] numerator,
  input  logic [VALUE_BITS-1:0] denominator,
  output logic                  done,
  output logic [VALUE_BITS-1:0] reduced_numerator,
  output logic [VALUE_BITS-1:0] reduced_denominator,
  output fr_pkg::form_t         form
);
  import fr_pkg::*;

  fr_cmd_t    cmd;
  fr_status_t status;

  fr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .status(status),
    .cmd   (cmd)
  );

  fr_datapath #(.W(VALUE_BITS)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .numerator          (numerator),
    .denominator        (denominator),
    .reduced_numerator  (reduced_numerator),
    .reduced_denominator(reduced_denominator),
    .form               (form),
    .done               (done)
  );

endmodule
